FILE: src/fgs_pkg.sv
// Shared constants for the finger galloping search unit.
// Used by the top level and the testbench; no dependencies.
package fgs_pkg;

  localparam int IDX_W   = 10;
  localparam int DEPTH   = 1 << IDX_W;
  localparam int CNT_W   = IDX_W + 1;
  localparam int VAL_W   = 48;
  localparam int OP_W    = 2;
  localparam int PADDR_W = 3;
  localparam int PDATA_W = 32;

  localparam logic [OP_W-1:0] OP_WRITE = 2'd0;
  localparam logic [OP_W-1:0] OP_SUCC  = 2'd1;
  localparam logic [OP_W-1:0] OP_PRED  = 2'd2;

  // register select is paddr[2]: element_count lives at byte address 0
  localparam logic REG_COUNT = 1'b0;

  localparam logic [CNT_W-1:0] COUNT_RESET = CNT_W'(1);

endpackage

FILE: src/fgs_ram.sv
// Single-port-write, single-port-read store with registered read data.
// Generic; sized by its parameters, no package dependency.
module fgs_ram #(
  parameter int ADDR_W = 10,
  parameter int DATA_W = 48
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [DATA_W-1:0] wdata,
  input  logic              re,
  input  logic [ADDR_W-1:0] raddr,
  output logic [DATA_W-1:0] rdata
);

  logic [DATA_W-1:0] mem [1 << ADDR_W];
  logic [DATA_W-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // read data holds while no read is issued
  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

FILE: src/finger_galloping_search_unit.sv
// Finger galloping search over a sorted store; top level with the search sequencer.
// Depends on fgs_pkg and fgs_ram.
//
// The unit keeps an ascending array of up to 1024 48-bit elements and a finger
// index. A write item stores one element and resets the finger; an unused
// opcode changes nothing. A successor or predecessor query reads the last and
// first elements, then the finger entry, gallops away from the finger in
// doubling steps, binary-searches the bracket and rereads the hit. Every step
// is one read of the single read port of the store. Queries are handled one at
// a time; the next item is taken once the result is in the output register and
// the receiver is not stalling.
module finger_galloping_search_unit
  import fgs_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  // input items
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [OP_W-1:0]    in_opcode,
  input  logic [IDX_W-1:0]   in_write_index,
  input  logic [VAL_W-1:0]   in_value,
  // result items
  output logic               out_valid,
  input  logic               out_stall,
  output logic               out_found,
  output logic [IDX_W-1:0]   out_hit_index,
  output logic [VAL_W-1:0]   out_hit_value,
  // configuration
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [PDATA_W-1:0] pwdata,
  output logic [PDATA_W-1:0] prdata,
  output logic               pready
);

  typedef enum logic [7:0] {
    S_IDLE = 8'b0000_0001,
    S_A    = 8'b0000_0010,   // rdata: bound element (last for succ, first for pred)
    S_B    = 8'b0000_0100,   // rdata: other bound element
    S_P    = 8'b0000_1000,   // rdata: finger element
    S_BK   = 8'b0001_0000,   // rdata: hi - d
    S_FW   = 8'b0010_0000,   // rdata: lo + d
    S_BSET = 8'b0100_0000,
    S_BIN  = 8'b1000_0000    // rdata: mid
  } state_t;

  // result hand-off, tracked beside the search state
  typedef enum logic [1:0] {
    R_IDLE = 2'b01,
    R_DONE = 2'b10
  } res_t;

  function automatic logic [IDX_W-1:0] mid_of(input logic [IDX_W-1:0] lo,
                                              input logic [IDX_W-1:0] hi,
                                              input logic             up);
    logic [IDX_W:0] s;
    s = {1'b0, lo} + {1'b0, hi} + {{IDX_W{1'b0}}, up};
    return s[IDX_W:1];
  endfunction

  state_t              state_r, state_nxt;
  res_t                res_r, res_nxt;
  logic [CNT_W-1:0]    count_r;
  logic [CNT_W-1:0]    cnt_r, cnt_in;
  logic [IDX_W-1:0]    cntm1, cntm1_in, pos_in;
  logic [VAL_W-1:0]    key_r;
  logic                pred_r;
  logic [IDX_W-1:0]    lo_r, lo_nxt, hi_r, hi_nxt, mid_r, mid_nxt;
  logic [IDX_W:0]      d_r, d_nxt;
  logic                fnd_r, fnd_nxt;
  logic [IDX_W-1:0]    finger_r;

  logic                out_valid_r, out_found_r;
  logic [IDX_W-1:0]    out_hit_index_r;
  logic [VAL_W-1:0]    out_hit_value_r;

  logic                in_fire, is_query, out_free;
  logic                rd_en;
  logic [IDX_W-1:0]    rd_addr;
  logic [VAL_W-1:0]    rd_data;
  logic                lt, gt;

  logic [IDX_W:0]      d2, step_d, brk_d, fw_sum, fw_end;
  logic                bk_ok, fw_ok, bk_brk, fw_brk;
  logic [IDX_W-1:0]    bk_addr;

  logic                take_a;
  logic [IDX_W-1:0]    a_lo, a_hi, b_lo, b_hi, n_lo, n_hi;

  // ---------------- configuration port ----------------
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= COUNT_RESET;
    end else if (psel && penable && pwrite && paddr[2] == REG_COUNT) begin
      count_r <= pwdata[CNT_W-1:0];
    end
  end

  always_comb begin
    prdata = '0;
    if (paddr[2] == REG_COUNT) begin
      prdata = {{(PDATA_W-CNT_W){1'b0}}, count_r};
    end
  end

  // ---------------- item intake ----------------
  assign out_free = !out_valid_r || !out_stall;
  assign in_stall = (res_r != R_IDLE) || (state_r != S_IDLE) || !out_free;
  assign in_fire  = in_valid && !in_stall;
  assign is_query = (in_opcode == OP_SUCC) || (in_opcode == OP_PRED);

  always_comb begin
    cnt_in = count_r;
    if (count_r == '0) begin
      cnt_in = CNT_W'(1);
    end else if (count_r > CNT_W'(DEPTH)) begin
      cnt_in = CNT_W'(DEPTH);
    end
  end

  assign cntm1_in = IDX_W'(cnt_in - CNT_W'(1));
  assign pos_in   = (finger_r > cntm1_in) ? cntm1_in : finger_r;
  assign cntm1    = IDX_W'(cnt_r - CNT_W'(1));

  // ---------------- store ----------------
  fgs_ram #(
    .ADDR_W (IDX_W),
    .DATA_W (VAL_W)
  ) u_ram (
    .clk   (clk),
    .we    (in_fire && in_opcode == OP_WRITE),
    .waddr (in_write_index),
    .wdata (in_value),
    .re    (rd_en),
    .raddr (rd_addr),
    .rdata (rd_data)
  );

  // shared compare against the key
  assign lt = rd_data < key_r;
  assign gt = rd_data > key_r;

  // gallop step arithmetic
  assign d2      = {d_r[IDX_W-1:0], 1'b0};
  assign step_d  = (state_r == S_P) ? d_r : d2;
  assign bk_ok   = step_d <= {1'b0, hi_r};
  assign bk_addr = hi_r - step_d[IDX_W-1:0];
  assign fw_sum  = {1'b0, lo_r} + step_d;
  assign fw_ok   = fw_sum < cnt_r;
  assign fw_end  = {1'b0, lo_r} + brk_d;

  // binary step: both outcomes prepared, compare picks one
  always_comb begin
    if (!pred_r) begin
      take_a = lt;
      a_lo   = mid_r + IDX_W'(1);
      a_hi   = hi_r;
      b_lo   = lo_r;
      b_hi   = mid_r;
    end else begin
      take_a = gt;
      a_lo   = lo_r;
      a_hi   = mid_r - IDX_W'(1);
      b_lo   = mid_r;
      b_hi   = hi_r;
    end
    n_lo = take_a ? a_lo : b_lo;
    n_hi = take_a ? a_hi : b_hi;
  end

  // ---------------- sequencer ----------------
  always_comb begin
    state_nxt = state_r;
    res_nxt   = res_r;
    lo_nxt    = lo_r;
    hi_nxt    = hi_r;
    mid_nxt   = mid_r;
    d_nxt     = d_r;
    fnd_nxt   = fnd_r;
    rd_en     = 1'b0;
    rd_addr   = lo_r;
    bk_brk    = 1'b0;
    fw_brk    = 1'b0;
    brk_d     = d_r;

    unique case (state_r)
      S_IDLE: begin
        if (res_r == R_DONE) begin
          if (out_free) begin
            res_nxt = R_IDLE;
          end
        end else if (in_fire && is_query) begin
          rd_en     = 1'b1;
          rd_addr   = (in_opcode == OP_PRED) ? '0 : cntm1_in;
          lo_nxt    = pos_in;
          hi_nxt    = pos_in;
          d_nxt     = (IDX_W+1)'(1);
          state_nxt = S_A;
        end
      end
      S_A: begin
        if (pred_r ? gt : lt) begin
          // key outside the array
          fnd_nxt   = 1'b0;
          res_nxt   = R_DONE;
          state_nxt = S_IDLE;
        end else begin
          rd_en     = 1'b1;
          rd_addr   = pred_r ? cntm1 : '0;
          state_nxt = S_B;
        end
      end
      S_B: begin
        if (pred_r ? !gt : !lt) begin
          lo_nxt    = pred_r ? cntm1 : '0;
          rd_en     = 1'b1;
          rd_addr   = pred_r ? cntm1 : '0;
          fnd_nxt   = 1'b1;
          res_nxt   = R_DONE;
          state_nxt = S_IDLE;
        end else begin
          rd_en     = 1'b1;
          rd_addr   = lo_r;
          state_nxt = S_P;
        end
      end
      S_P: begin
        if (pred_r ? gt : !lt) begin
          if (bk_ok) begin
            rd_en     = 1'b1;
            rd_addr   = bk_addr;
            state_nxt = S_BK;
          end else begin
            bk_brk = 1'b1;
          end
        end else begin
          if (fw_ok) begin
            rd_en     = 1'b1;
            rd_addr   = fw_sum[IDX_W-1:0];
            state_nxt = S_FW;
          end else begin
            fw_brk = 1'b1;
          end
        end
      end
      S_BK: begin
        if (!gt) begin
          bk_brk = 1'b1;
        end else if (bk_ok) begin
          d_nxt   = d2;
          rd_en   = 1'b1;
          rd_addr = bk_addr;
        end else begin
          bk_brk = 1'b1;
          brk_d  = d2;
        end
      end
      S_FW: begin
        if (!lt) begin
          fw_brk = 1'b1;
        end else if (fw_ok) begin
          d_nxt   = d2;
          rd_en   = 1'b1;
          rd_addr = fw_sum[IDX_W-1:0];
        end else begin
          fw_brk = 1'b1;
          brk_d  = d2;
        end
      end
      S_BSET: begin
        if (hi_r > lo_r) begin
          mid_nxt   = mid_of(lo_r, hi_r, pred_r);
          rd_en     = 1'b1;
          rd_addr   = mid_nxt;
          state_nxt = S_BIN;
        end else begin
          rd_en     = 1'b1;
          rd_addr   = lo_r;
          fnd_nxt   = 1'b1;
          res_nxt   = R_DONE;
          state_nxt = S_IDLE;
        end
      end
      S_BIN: begin
        lo_nxt = n_lo;
        hi_nxt = n_hi;
        rd_en  = 1'b1;
        if (n_hi > n_lo) begin
          mid_nxt = mid_of(n_lo, n_hi, pred_r);
          rd_addr = mid_nxt;
        end else begin
          rd_addr   = n_lo;
          fnd_nxt   = 1'b1;
          res_nxt   = R_DONE;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    if (bk_brk) begin
      lo_nxt    = (brk_d > {1'b0, hi_r}) ? '0 : hi_r - brk_d[IDX_W-1:0];
      hi_nxt    = hi_r - brk_d[IDX_W:1];
      state_nxt = S_BSET;
    end

    if (fw_brk) begin
      if (!pred_r && brk_d == (IDX_W+1)'(1)) begin
        // successor right after the finger
        lo_nxt    = lo_r + IDX_W'(1);
        rd_en     = 1'b1;
        rd_addr   = lo_nxt;
        fnd_nxt   = 1'b1;
        res_nxt   = R_DONE;
        state_nxt = S_IDLE;
      end else begin
        hi_nxt    = (fw_end >= cnt_r) ? cntm1 : fw_end[IDX_W-1:0];
        lo_nxt    = lo_r + brk_d[IDX_W:1];
        state_nxt = S_BSET;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      res_r    <= R_IDLE;
      finger_r <= '0;
      fnd_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      res_r   <= res_nxt;
      fnd_r   <= fnd_nxt;
      if (in_fire && in_opcode == OP_WRITE) begin
        finger_r <= '0;
      end else if (res_r == R_DONE && out_free && fnd_r) begin
        finger_r <= lo_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    lo_r  <= lo_nxt;
    hi_r  <= hi_nxt;
    mid_r <= mid_nxt;
    d_r   <= d_nxt;
    if (in_fire) begin
      key_r  <= in_value;
      pred_r <= (in_opcode == OP_PRED);
      cnt_r  <= cnt_in;
    end
  end

  // ---------------- output register ----------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_fire && !is_query) begin
      out_valid_r <= 1'b1;
    end else if (res_r == R_DONE && out_free) begin
      out_valid_r <= 1'b1;
    end else if (out_valid_r && !out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire && !is_query) begin
      out_found_r     <= 1'b0;
      out_hit_index_r <= '0;
      out_hit_value_r <= '0;
    end else if (res_r == R_DONE && out_free) begin
      out_found_r     <= fnd_r;
      out_hit_index_r <= fnd_r ? lo_r : '0;
      out_hit_value_r <= fnd_r ? rd_data : '0;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_found     = out_found_r;
  assign out_hit_index = out_hit_index_r;
  assign out_hit_value = out_hit_value_r;

  // ---------------- checks ----------------
  a_bin_bracket: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_BIN) |-> (hi_r > lo_r))
    else $error("binary step entered with empty bracket");

  a_fw_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_FW) |-> (({1'b0, lo_r} + d_r) < cnt_r))
    else $error("forward probe beyond element count");

  a_bk_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_BK) |-> (d_r <= {1'b0, hi_r}))
    else $error("backward probe below index zero");

  a_busy_stall: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != S_IDLE || res_r != R_IDLE) |-> in_stall)
    else $error("item intake open while a query is in progress");

endmodule

FILE: sim/finger_galloping_search_unit_test.sv
// Self-checking testbench for finger_galloping_search_unit: directed and random items,
// each result checked against a behavioral predictor of the finger galloping search.
// Depends on fgs_pkg and the unit's RTL only.
module finger_galloping_search_unit_test;
  timeunit 1ns;
  timeprecision 1ps;
  import fgs_pkg::*;

  localparam int CLK_PERIOD    = 8;
  localparam int SETTLE_CYCLES = 40;
  localparam int PHASE_ITEMS   = 25;
  localparam int NUM_PHASES    = 10;
  localparam int MAX_PRINTED   = 100;

  localparam logic [OP_W-1:0]    OP_UNUSED  = 2'd3;
  localparam logic [PADDR_W-1:0] COUNT_ADDR = {REG_COUNT, 2'b00};
  localparam logic [VAL_W-1:0]   VALUE_MAX  = '1;
  localparam logic [VAL_W-1:0]   MID_VALUE  = 48'h8000_0000_0001;

  typedef struct packed {
    logic [OP_W-1:0]  opcode;
    logic [IDX_W-1:0] write_index;
    logic [VAL_W-1:0] value;
  } search_item_t;

  typedef struct packed {
    logic             found;
    logic [IDX_W-1:0] hit_index;
    logic [VAL_W-1:0] hit_value;
  } search_result_t;

  logic               clk            = 1'b0;
  logic               rst_n          = 1'b0;
  logic               in_valid       = 1'b0;
  logic               in_stall;
  logic [OP_W-1:0]    in_opcode      = OP_UNUSED;
  logic [IDX_W-1:0]   in_write_index = '0;
  logic [VAL_W-1:0]   in_value       = '0;
  logic               out_valid;
  logic               out_stall      = 1'b0;
  logic               out_found;
  logic [IDX_W-1:0]   out_hit_index;
  logic [VAL_W-1:0]   out_hit_value;
  logic               psel           = 1'b0;
  logic               penable        = 1'b0;
  logic               pwrite         = 1'b0;
  logic [PADDR_W-1:0] paddr          = '0;
  logic [PDATA_W-1:0] pwdata         = '0;
  logic [PDATA_W-1:0] prdata;
  logic               pready;

  search_item_t   queued_items[$];
  search_result_t awaited_results[$];
  search_item_t   next_item;
  search_result_t oldest_result;

  // predictor state
  logic [VAL_W-1:0] shadow_postings [DEPTH];
  logic [IDX_W-1:0] shadow_finger = '0;
  logic [CNT_W-1:0] shadow_count  = COUNT_RESET;

  // contents the stimulus expects the store to hold, kept ascending
  logic [VAL_W-1:0] planned_postings [DEPTH];

  int unsigned send_gap_pct = 0;
  int unsigned stall_pct    = 0;
  int          error_count  = 0;

  finger_galloping_search_unit uut (.*);

  always #(CLK_PERIOD / 2) clk = ~clk;

  task automatic report_mismatch(string what);
    if (error_count < MAX_PRINTED)
      $display("ERROR @%0t: %s", $realtime, what);
    error_count++;
  endtask

  function automatic logic [VAL_W-1:0] posting_at(int i);
    if (i < 0 || i >= DEPTH) return '0;
    return shadow_postings[i];
  endfunction

  // first element >= key, galloping from the finger
  function automatic int successor_index(int cnt, int pos, logic [VAL_W-1:0] key);
    int lo, hi, step, mid;
    step = 1;
    if (key <= posting_at(0)) return 0;
    lo = pos;
    hi = pos;
    if (posting_at(lo) >= key) begin
      while (hi - step >= 0) begin
        if (posting_at(hi - step) <= key) break;
        step = step + step;
      end
      lo = hi - step;
      hi = hi - (step >> 1);
      if (lo < 0) lo = 0;
    end else begin
      while (lo + step < cnt) begin
        if (posting_at(lo + step) >= key) break;
        step = step + step;
      end
      if (step == 1) return lo + 1;
      hi = lo + step;
      lo = lo + (step >> 1);
      if (hi >= cnt) hi = cnt - 1;
    end
    while (hi > lo) begin
      mid = (hi + lo) >> 1;
      if (posting_at(mid) < key) lo = mid + 1;
      else hi = mid;
    end
    return lo;
  endfunction

  // last element <= key, galloping from the finger
  function automatic int predecessor_index(int cnt, int pos, logic [VAL_W-1:0] key);
    int lo, hi, step, mid;
    step = 1;
    if (key >= posting_at(cnt - 1)) return cnt - 1;
    lo = pos;
    hi = pos;
    if (posting_at(lo) > key) begin
      while (hi - step >= 0) begin
        if (posting_at(hi - step) <= key) break;
        step = step + step;
      end
      lo = hi - step;
      hi = hi - (step >> 1);
      if (lo < 0) lo = 0;
    end else begin
      while (lo + step < cnt) begin
        if (posting_at(lo + step) >= key) break;
        step = step + step;
      end
      hi = lo + step;
      lo = lo + (step >> 1);
      if (hi >= cnt) hi = cnt - 1;
    end
    while (hi > lo) begin
      mid = (hi + lo + 1) >> 1;
      if (posting_at(mid) > key) hi = mid - 1;
      else lo = mid;
    end
    return lo;
  endfunction

  function automatic void compute_search_result(logic [OP_W-1:0] opcode,
      logic [IDX_W-1:0] write_index, logic [VAL_W-1:0] value);
    int cnt, pos, hit;
    search_result_t res;
    cnt = int'(shadow_count);
    if (cnt < 1) cnt = 1;
    if (cnt > DEPTH) cnt = DEPTH;
    pos = int'(shadow_finger);
    if (pos > cnt - 1) pos = cnt - 1;
    hit = -1;
    res = '0;
    case (opcode)
      OP_WRITE: begin
        shadow_postings[write_index] = value;
        shadow_finger = '0;
      end
      OP_SUCC: begin
        if (value <= posting_at(cnt - 1)) hit = successor_index(cnt, pos, value);
      end
      OP_PRED: begin
        if (value >= posting_at(0)) hit = predecessor_index(cnt, pos, value);
      end
      default: ;
    endcase
    if (hit >= 0) begin
      shadow_finger = IDX_W'(hit);
      res.found = 1'b1;
      res.hit_index = IDX_W'(hit);
      res.hit_value = posting_at(hit);
    end
    awaited_results.push_back(res);
  endfunction

  function automatic logic [VAL_W-1:0] random_value();
    return VAL_W'({$urandom, $urandom});
  endfunction

  function automatic logic [VAL_W-1:0] value_between(logic [VAL_W-1:0] lo,
      logic [VAL_W-1:0] hi);
    logic [63:0] span;
    if (hi < lo) return lo;
    span = 64'(hi) - 64'(lo) + 64'd1;
    return lo + VAL_W'({$urandom, $urandom} % span);
  endfunction

  function automatic void queue_item(logic [OP_W-1:0] opcode, logic [IDX_W-1:0] idx,
      logic [VAL_W-1:0] value);
    search_item_t item;
    item.opcode = opcode;
    item.write_index = idx;
    item.value = value;
    queued_items.push_back(item);
    if (opcode == OP_WRITE) planned_postings[idx] = value;
  endfunction

  function automatic logic [OP_W-1:0] random_query_op();
    return ($urandom_range(1) != 0) ? OP_SUCC : OP_PRED;
  endfunction

  // keys near stored elements, between them, past both ends, or anywhere
  function automatic logic [VAL_W-1:0] pick_key(int eff);
    int i;
    i = $urandom_range(eff - 1);
    case ($urandom_range(8))
      0:       return planned_postings[i];
      1:       return planned_postings[i] + 1'b1;
      2:       return planned_postings[i] - 1'b1;
      3, 4: begin
        if (i + 1 < eff) return value_between(planned_postings[i], planned_postings[i + 1]);
        return random_value();
      end
      5:       return random_value();
      6:       return planned_postings[eff - 1] + VAL_W'($urandom_range(1, 4));
      7:       return planned_postings[0] - VAL_W'($urandom_range(1, 4));
      default: return ($urandom_range(1) != 0) ? VALUE_MAX : '0;
    endcase
  endfunction

  // keeps the store ascending
  function automatic logic [VAL_W-1:0] sorted_value_for(int slot);
    logic [VAL_W-1:0] lo, hi;
    lo = (slot == 0) ? '0 : planned_postings[slot - 1];
    hi = (slot == DEPTH - 1) ? VALUE_MAX : planned_postings[slot + 1];
    return value_between(lo, hi);
  endfunction

  task automatic wait_until_idle();
    while (queued_items.size() != 0 || in_valid || awaited_results.size() != 0)
      @(negedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_element_count(logic [CNT_W-1:0] count_value);
    logic [PDATA_W-1:0] wdata;
    wdata = $urandom;
    wdata[CNT_W-1:0] = count_value;
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= COUNT_ADDR;
    pwdata <= wdata;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    shadow_count = count_value;
    // read back through a second transfer
    pwrite <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    if (prdata[CNT_W-1:0] !== count_value)
      report_mismatch($sformatf("element_count read back %0d, wrote %0d",
                                prdata[CNT_W-1:0], count_value));
    psel <= 1'b0;
    penable <= 1'b0;
  endtask

  // input driver: prediction is made at the edge where the item is taken
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall)
        compute_search_result(in_opcode, in_write_index, in_value);
      if (!in_valid || !in_stall) begin
        if (queued_items.size() != 0 && $urandom_range(99) >= send_gap_pct) begin
          next_item = queued_items.pop_front();
          in_valid <= 1'b1;
          in_opcode <= next_item.opcode;
          in_write_index <= next_item.write_index;
          in_value <= next_item.value;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // result monitor and receiver stall
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (awaited_results.size() == 0) begin
          report_mismatch("result item with no item outstanding");
        end else begin
          oldest_result = awaited_results.pop_front();
          if (out_found !== oldest_result.found)
            report_mismatch($sformatf("found %0b, expected %0b",
                                      out_found, oldest_result.found));
          if (out_hit_index !== oldest_result.hit_index)
            report_mismatch($sformatf("hit_index %0d, expected %0d",
                                      out_hit_index, oldest_result.hit_index));
          if (out_hit_value !== oldest_result.hit_value)
            report_mismatch($sformatf("hit_value %h, expected %h",
                                      out_hit_value, oldest_result.hit_value));
        end
      end
      out_stall <= ($urandom_range(99) < stall_pct);
    end
  end

  initial begin : stimulus
    int p, k, slot, eff;
    logic [CNT_W-1:0] count_sel;
    logic [VAL_W-1:0] saved;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // directed: one element in use, ends of the value range, misses at both ends
    queue_item(OP_WRITE, '0, MID_VALUE);
    queue_item(OP_SUCC, '0, MID_VALUE - 1'b1);
    queue_item(OP_SUCC, '0, MID_VALUE);
    queue_item(OP_SUCC, '0, MID_VALUE + 1'b1);
    queue_item(OP_PRED, '0, MID_VALUE - 1'b1);
    queue_item(OP_PRED, '0, MID_VALUE);
    queue_item(OP_PRED, '1, VALUE_MAX);
    queue_item(OP_SUCC, '1, '0);
    queue_item(OP_UNUSED, '1, VALUE_MAX);
    queue_item(OP_WRITE, '0, '0);
    queue_item(OP_PRED, '0, '0);
    queue_item(OP_SUCC, '0, VALUE_MAX);
    queue_item(OP_WRITE, '0, VALUE_MAX);
    queue_item(OP_SUCC, '0, VALUE_MAX);
    queue_item(OP_PRED, '0, VALUE_MAX - 1'b1);
    queue_item(OP_SUCC, '0, '0);
    queue_item(OP_UNUSED, '0, '0);
    wait_until_idle();

    // fill every slot with an ascending sequence
    send_gap_pct = 11;
    stall_pct = 11;
    for (k = 0; k < DEPTH; k++)
      queue_item(OP_WRITE, IDX_W'(k),
                 (VAL_W'(k) << (VAL_W - IDX_W)) | (random_value() >> (IDX_W + 1)));
    wait_until_idle();

    for (p = 0; p < NUM_PHASES; p++) begin
      case (p)
        0:       count_sel = CNT_W'(DEPTH);
        1:       count_sel = '1;               // above DEPTH
        2:       count_sel = CNT_W'(3);
        3:       count_sel = '0;               // acts as one element
        4:       count_sel = CNT_W'(1000);
        5:       count_sel = CNT_W'(2);
        6:       count_sel = CNT_W'($urandom_range(4, DEPTH - 1));
        7:       count_sel = CNT_W'(DEPTH + 1);
        8:       count_sel = CNT_W'(1);
        default: count_sel = CNT_W'(DEPTH);
      endcase
      write_element_count(count_sel);
      eff = (count_sel == 0) ? 1 : (count_sel > DEPTH) ? DEPTH : int'(count_sel);
      send_gap_pct = (p % 4 == 1) ? 49 : (p % 4 == 3) ? 11 : 0;
      stall_pct    = (p % 4 == 2) ? 49 : (p % 4 == 3) ? 11 : 0;

      k = 0;
      while (k < PHASE_ITEMS) begin
        slot = $urandom_range(DEPTH - 1);
        case ($urandom_range(99)) inside
          [0:71]: begin
            queue_item(random_query_op(), IDX_W'($urandom), pick_key(eff));
            k++;
          end
          [72:83]: begin
            queue_item(OP_WRITE, IDX_W'(slot), sorted_value_for(slot));
            k++;
          end
          [84:89]: begin
            // out-of-order element, one query, then put it back
            saved = planned_postings[slot];
            queue_item(OP_WRITE, IDX_W'(slot), random_value());
            queue_item(random_query_op(), IDX_W'($urandom), pick_key(eff));
            queue_item(OP_WRITE, IDX_W'(slot), saved);
            k += 3;
          end
          [90:94]: begin
            queue_item(OP_UNUSED, IDX_W'($urandom), random_value());
            k++;
          end
          default: begin
            queue_item(random_query_op(), IDX_W'($urandom),
                       ($urandom_range(1) != 0) ? VALUE_MAX : '0);
            k++;
          end
        endcase
      end
      // leave the finger on the last element in use for the next setting
      queue_item(OP_SUCC, IDX_W'($urandom), planned_postings[eff - 1]);
      wait_until_idle();
    end

    wait_until_idle();
    if (error_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  initial begin
    #10ms;
    $display("TIMEOUT: results still outstanding");
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
